FILE: src/avii_pkg.sv
// package for the angular view index interpolator
// holds widths, function codes, state enum and cordic table; no dependencies
`timescale 1ns / 1ps
package avii_pkg;

  localparam int ANG_BITS = 30;
  localparam logic [31:0] TAN_MAX = 32'h7FFF_FFFF;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    REG_NUM_VIEWS    = 3'd0,
    REG_IMAGE_WIDTH  = 3'd1,
    REG_SCREEN_WIDTH = 3'd2,
    REG_PROJ_X       = 3'd3,
    REG_PROJ_Z       = 3'd4
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SX_MUL,
    ST_SX_DIV,
    ST_T_DIV,
    ST_RD_L,
    ST_RD_R,
    ST_LT_DIV,
    ST_RT_DIV,
    ST_CHECK,
    ST_RD_M,
    ST_MT_DIV,
    ST_SEARCH,
    ST_ATAN_T,
    ST_ATAN_L,
    ST_ATAN_R,
    ST_W_PREP,
    ST_W_DIV,
    ST_DONE,
    ST_OUT
  } state_t;

  // cordic arctangent of 2^-i in q2.30 for the first ten steps
  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0: a = 32'd843314857;
      5'd1: a = 32'd497837829;
      5'd2: a = 32'd263043837;
      5'd3: a = 32'd133525159;
      5'd4: a = 32'd67021687;
      5'd5: a = 32'd33543516;
      5'd6: a = 32'd16775851;
      5'd7: a = 32'd8388437;
      5'd8: a = 32'd4194283;
      5'd9: a = 32'd2097149;
      default: a = 32'd1 << (5'd30 - i);
    endcase
    return a;
  endfunction

endpackage

FILE: src/avii_if.sv
// valid/ready channel interfaces for input items and results
// depends on nothing
`timescale 1ns / 1ps
interface avii_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [5:0]  view_slot;
  logic signed [31:0] view_x;
  logic signed [31:0] view_z;
  logic [11:0] column;
  modport source (output valid, func, view_slot, view_x, view_z, column, input ready);
  modport sink (input valid, func, view_slot, view_x, view_z, column, output ready);
endinterface

interface avii_out_if #(parameter int FRAC_BITS = 16);
  logic                 valid;
  logic                 ready;
  logic [5:0]           left_view;
  logic [FRAC_BITS:0]   blend_weight;
  modport source (output valid, left_view, blend_weight, input ready);
  modport sink (input valid, left_view, blend_weight, output ready);
endinterface

FILE: src/avii_ram.sv
// generic single-port-write ram with registered read
// no dependencies
`timescale 1ns / 1ps
module avii_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: src/avii_divider.sv
// restoring unsigned divider, one quotient bit per cycle
// no dependencies
`timescale 1ns / 1ps
module avii_divider #(
  parameter int NW = 64,
  parameter int DW = 48
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] q;
  logic [DW:0]   rem;
  logic [DW-1:0] d;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;

  assign trial = {rem[DW-1:0], q[NW-1]};
  assign quo   = q;

  // shift in one numerator bit, subtract when it fits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        q    <= num;
        rem  <= '0;
        d    <= den;
        cnt  <= CW'(NW);
      end else if (busy) begin
        if (trial >= {1'b0, d}) begin
          rem <= trial - {1'b0, d};
          q   <= {q[NW-2:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: src/avii_cordic.sv
// cordic vectoring arctangent, one micro-rotation per cycle
// depends on avii_pkg for the angle table
`timescale 1ns / 1ps
module avii_cordic #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic signed [31:0] tan_in,
  output logic        done,
  output logic signed [33:0] angle
);
  localparam int XW = 66;
  logic signed [XW-1:0] x, y;
  logic signed [33:0]   z;
  logic [4:0]           i;
  logic                 busy;

  assign angle = z;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        x    <= XW'(64'sd1 << avii_pkg::ANG_BITS);
        y    <= XW'(tan_in) <<< (avii_pkg::ANG_BITS - FRAC_BITS);
        z    <= '0;
        i    <= '0;
      end else if (busy) begin
        // rotate toward y = 0
        if (!y[XW-1]) begin
          x <= x + (y >>> i);
          y <= y - (x >>> i);
          z <= z + $signed({2'b00, avii_pkg::atan_entry(i)});
        end else begin
          x <= x - (y >>> i);
          y <= y + (x >>> i);
          z <= z - $signed({2'b00, avii_pkg::atan_entry(i)});
        end
        i <= i + 1'b1;
        if (i == 5'(avii_pkg::ANG_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: src/angular_view_index_interpolator.sv
// top level: view table memories, apb registers and query sequencer
// depends on avii_pkg, avii_if, avii_ram, avii_divider, avii_cordic
// one item at a time: items are accepted only while idle, a load is written to the view
//   tables as it is accepted, and a result may wait at the output
// reset: registers take their reset values, table contents stay undefined
`timescale 1ns / 1ps
module angular_view_index_interpolator #(
  parameter int MAX_VIEWS   = 64,
  parameter int MAX_COLUMNS = 4096,
  parameter int FRAC_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  avii_in_if.sink     in_ch,
  avii_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int AW  = $clog2(MAX_VIEWS);
  localparam int NVW = $clog2(MAX_VIEWS + 1);
  localparam int CLW = $clog2(MAX_COLUMNS);

  // configuration registers
  logic [6:0]  num_views;
  logic [12:0] image_width;
  logic [30:0] screen_width;
  logic [31:0] proj_x, proj_z;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      num_views    <= 7'd2;
      image_width  <= 13'd1024;
      screen_width <= 31'd65536;
      proj_x       <= '0;
      proj_z       <= 32'd65536;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        avii_pkg::REG_NUM_VIEWS:    num_views    <= pwdata[6:0];
        avii_pkg::REG_IMAGE_WIDTH:  image_width  <= pwdata[12:0];
        avii_pkg::REG_SCREEN_WIDTH: screen_width <= pwdata[30:0];
        avii_pkg::REG_PROJ_X:       proj_x       <= pwdata;
        avii_pkg::REG_PROJ_Z:       proj_z       <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      avii_pkg::REG_NUM_VIEWS:    prdata = {25'd0, num_views};
      avii_pkg::REG_IMAGE_WIDTH:  prdata = {19'd0, image_width};
      avii_pkg::REG_SCREEN_WIDTH: prdata = {1'b0, screen_width};
      avii_pkg::REG_PROJ_X:       prdata = proj_x;
      avii_pkg::REG_PROJ_Z:       prdata = proj_z;
      default:                    prdata = '0;
    endcase
  end

  // sequencer state
  avii_pkg::state_t state, state_next;
  logic [AW-1:0]  lo, hi, mid, raddr;
  logic [NVW-1:0] nv;
  logic signed [63:0] sx;
  logic signed [63:0] prod;
  logic signed [46:0] sw_term;
  logic signed [31:0] t, lt, rt, tan_r;
  logic signed [33:0] ta, la;
  logic [FRAC_BITS:0] w, res_w;
  logic [5:0]  res_view, view_fin;
  logic        res_valid;
  logic        no_order;
  logic        tan_neg, tan_sat, tan_zero, tan_fix;
  logic signed [47:0] tnum, tden;
  logic [47:0] an_mag, ad_mag;
  logic        wneg;

  // table memories
  logic        load_we;
  logic [31:0] xr, zr;
  assign load_we = in_ch.valid && in_ch.ready && in_ch.func == avii_pkg::FUNC_LOAD &&
                   {2'b0, in_ch.view_slot} < 8'(MAX_VIEWS);

  avii_ram #(.WIDTH(32), .DEPTH(MAX_VIEWS)) u_xram (
    .clk(clk), .we(load_we), .waddr(AW'(in_ch.view_slot)), .wdata(in_ch.view_x),
    .raddr(raddr), .rdata(xr));
  avii_ram #(.WIDTH(32), .DEPTH(MAX_VIEWS)) u_zram (
    .clk(clk), .we(load_we), .waddr(AW'(in_ch.view_slot)), .wdata(in_ch.view_z),
    .raddr(raddr), .rdata(zr));

  // shared divider
  logic        div_start, div_done;
  logic [63:0] div_num, div_quo;
  logic [47:0] div_den;
  avii_divider #(.NW(64), .DW(48)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo));

  // shared cordic
  logic        cor_start, cor_done;
  logic signed [31:0] cor_in;
  logic signed [33:0] cor_ang;
  avii_cordic #(.FRAC_BITS(FRAC_BITS)) u_cor (
    .clk(clk), .rst(rst), .start(cor_start), .tan_in(cor_in),
    .done(cor_done), .angle(cor_ang));

  logic [12:0] wd;
  logic [CLW-1:0] col;
  logic signed [14:0] mterm;
  assign wd = (image_width == 13'd0) ? 13'd1 : image_width;

  // tangent numerator and denominator, selected by state
  always_comb begin
    if (state == avii_pkg::ST_SX_DIV || state == avii_pkg::ST_T_DIV) begin
      tnum = 48'(sx) - 48'(signed'(proj_x));
      tden = -48'(signed'(proj_z));
    end else begin
      tnum = 48'(sx) - 48'(signed'(xr));
      tden = -48'(signed'(zr));
    end
  end

  logic [47:0] tn_mag, td_mag;
  logic        tan_fix_n;
  assign tn_mag = tnum[47] ? 48'(-tnum) : 48'(tnum);
  assign td_mag = tden[47] ? 48'(-tden) : 48'(tden);
  // zero, saturated or zero-denominator tangent needs no divide
  assign tan_fix_n = (tnum == 48'sd0) || (tden == 48'sd0) ||
                     (tn_mag >= (td_mag << (31 - FRAC_BITS)));
  // screen x divides by twice the image width
  assign div_den = (state == avii_pkg::ST_W_PREP) ? ad_mag :
                   (state == avii_pkg::ST_SX_MUL) ? 48'({wd, 1'b0}) : td_mag;

  // division result to saturated signed tangent
  assign tan_r = tan_zero ? 32'sd0 :
                 tan_sat  ? (tan_neg ? -$signed(avii_pkg::TAN_MAX) : $signed(avii_pkg::TAN_MAX)) :
                 (tan_neg ? -$signed(div_quo[31:0]) : $signed(div_quo[31:0]));

  // next state and strobes
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_num    = {16'd0, tn_mag} << FRAC_BITS;
    cor_start  = 1'b0;
    cor_in     = t;
    raddr      = lo;
    unique case (state)
      avii_pkg::ST_IDLE:
        if (in_ch.valid && in_ch.func == avii_pkg::FUNC_QUERY) state_next = avii_pkg::ST_SX_MUL;
      avii_pkg::ST_SX_MUL: begin
        div_start  = 1'b1;
        div_num    = prod[63] ? 64'(-prod) : 64'(prod);
        state_next = avii_pkg::ST_SX_DIV;
      end
      avii_pkg::ST_SX_DIV:
        if (div_done) state_next = avii_pkg::ST_T_DIV;
      avii_pkg::ST_T_DIV: begin
        if (!tan_fix_n) div_start = 1'b1;
        state_next = avii_pkg::ST_RD_L;
      end
      avii_pkg::ST_RD_L: begin
        raddr = lo;
        if (tan_fix || div_done) state_next = avii_pkg::ST_RD_R;
      end
      avii_pkg::ST_RD_R: begin
        raddr = lo;
        if (!tan_fix_n) div_start = 1'b1;
        state_next = avii_pkg::ST_LT_DIV;
      end
      avii_pkg::ST_LT_DIV: begin
        raddr = hi;
        if (tan_fix || div_done) state_next = avii_pkg::ST_RT_DIV;
      end
      avii_pkg::ST_RT_DIV: begin
        raddr = hi;
        if (!tan_fix_n) div_start = 1'b1;
        state_next = avii_pkg::ST_CHECK;
      end
      avii_pkg::ST_CHECK: begin
        raddr = hi;
        if (tan_fix || div_done) state_next = avii_pkg::ST_SEARCH;
      end
      avii_pkg::ST_SEARCH: begin
        raddr = mid;
        if (no_order) state_next = avii_pkg::ST_DONE;
        else if (hi - lo > AW'(1)) state_next = avii_pkg::ST_RD_M;
        else begin
          cor_start  = 1'b1;
          cor_in     = t;
          state_next = avii_pkg::ST_ATAN_T;
        end
      end
      avii_pkg::ST_RD_M: begin
        raddr = mid;
        if (!tan_fix_n) div_start = 1'b1;
        state_next = avii_pkg::ST_MT_DIV;
      end
      avii_pkg::ST_MT_DIV: begin
        raddr = mid;
        if (tan_fix || div_done) state_next = avii_pkg::ST_SEARCH;
      end
      avii_pkg::ST_ATAN_T:
        if (cor_done) begin
          cor_start = 1'b1; cor_in = lt; state_next = avii_pkg::ST_ATAN_L;
        end
      avii_pkg::ST_ATAN_L:
        if (cor_done) begin
          cor_start = 1'b1; cor_in = rt; state_next = avii_pkg::ST_ATAN_R;
        end
      avii_pkg::ST_ATAN_R:
        if (cor_done) state_next = avii_pkg::ST_W_PREP;
      avii_pkg::ST_W_PREP: begin
        div_num = {16'd0, an_mag} << FRAC_BITS;
        if (ad_mag != 48'd0 && an_mag != 48'd0 && !wneg && an_mag < ad_mag)
          div_start = 1'b1;
        state_next = avii_pkg::ST_W_DIV;
      end
      avii_pkg::ST_W_DIV:
        if (!div_start && (ad_mag == 48'd0 || an_mag == 48'd0 || wneg || an_mag >= ad_mag
            || div_done)) state_next = avii_pkg::ST_DONE;
      avii_pkg::ST_DONE:   state_next = avii_pkg::ST_OUT;
      avii_pkg::ST_OUT:
        if (!res_valid || out_ch.ready) state_next = avii_pkg::ST_IDLE;
      default: state_next = avii_pkg::ST_IDLE;
    endcase
  end

  assign in_ch.ready = (state == avii_pkg::ST_IDLE);
  assign mid = AW'(({1'b0, lo} + {1'b0, hi}) >> 1);
  assign col = CLW'(in_ch.column);
  assign mterm = 15'(signed'({2'b0, col, 1'b1})) - 15'(signed'({2'b0, wd}));
  assign sw_term = signed'({1'b0, screen_width}) * mterm;

  logic signed [34:0] an_s, ad_s;
  assign an_s = 35'(ta) - 35'(la);
  assign ad_s = 35'(cor_ang) - 35'(la);

  // state register and output beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= avii_pkg::ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == avii_pkg::ST_OUT && (!res_valid || out_ch.ready)) res_valid <= 1'b1;
      else if (out_ch.ready) res_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      avii_pkg::ST_IDLE: begin
        prod <= 64'(sw_term);
        nv   <= (num_views < 7'd2) ? NVW'(2) :
                ({1'b0, num_views} > 8'(MAX_VIEWS)) ? NVW'(MAX_VIEWS) : NVW'(num_views);
      end
      avii_pkg::ST_SX_MUL: begin
        lo <= '0;
        hi <= AW'(nv - 1'b1);
        tan_neg <= prod[63];
      end
      avii_pkg::ST_SX_DIV: ;
      default: ;
    endcase
    // screen x, truncated toward zero
    if (state == avii_pkg::ST_SX_DIV && div_done)
      sx <= tan_neg ? -$signed(div_quo) : $signed(div_quo);
    // latch sign, zero, saturation and fix flags of the tangent that is about to be divided
    if (state == avii_pkg::ST_T_DIV || state == avii_pkg::ST_RD_R ||
        state == avii_pkg::ST_RT_DIV || state == avii_pkg::ST_RD_M) begin
      tan_neg  <= tnum[47] ^ tden[47];
      tan_zero <= tnum == 48'sd0;
      tan_sat  <= (tnum != 48'sd0) &&
                  (tden == 48'sd0 || tn_mag >= (td_mag << (31 - FRAC_BITS)));
      tan_fix  <= tan_fix_n;
    end
    if (state == avii_pkg::ST_RD_L && (tan_fix || div_done)) t  <= tan_r;
    if (state == avii_pkg::ST_LT_DIV && (tan_fix || div_done)) lt <= tan_r;
    if (state == avii_pkg::ST_CHECK && (tan_fix || div_done)) begin
      rt       <= tan_r;
      no_order <= lt > tan_r;
    end
    if (state == avii_pkg::ST_MT_DIV && (tan_fix || div_done)) begin
      if (tan_r > t) begin hi <= mid; rt <= tan_r; end
      else begin lo <= mid; lt <= tan_r; end
    end
    if (state == avii_pkg::ST_ATAN_T && cor_done) ta <= cor_ang;
    if (state == avii_pkg::ST_ATAN_L && cor_done) la <= cor_ang;
    // weight selection
    if (state == avii_pkg::ST_W_DIV) begin
      if (ad_mag == 48'd0) w <= (!wneg && an_mag != 48'd0) ? (FRAC_BITS+1)'(1) << FRAC_BITS : '0;
      else if (an_mag == 48'd0 || wneg) w <= '0;
      else if (an_mag >= ad_mag) w <= (FRAC_BITS+1)'(1) << FRAC_BITS;
      else w <= (FRAC_BITS+1)'(div_quo);
    end
    if (state == avii_pkg::ST_DONE) begin
      if (no_order) begin
        view_fin <= '0;
        w        <= '0;
      end else if (w[FRAC_BITS] && {1'b0, lo} + 1'b1 <= {1'b0, AW'(nv - 2'd2)}) begin
        view_fin <= 6'(lo + 1'b1);
        w        <= '0;
      end else begin
        view_fin <= 6'(lo);
      end
    end
    // output register, loaded once the previous beat has left
    if (state == avii_pkg::ST_OUT && (!res_valid || out_ch.ready)) begin
      res_view <= view_fin;
      res_w    <= w;
    end
  end

  // angle differences, registered as the last cordic run finishes
  logic wneg_n;
  assign wneg_n = an_s[34] != ad_s[34];
  always_ff @(posedge clk) begin
    if (state == avii_pkg::ST_ATAN_R && cor_done) begin
      an_mag <= an_s[34] ? 48'(-an_s) : 48'(an_s);
      ad_mag <= ad_s[34] ? 48'(-ad_s) : 48'(ad_s);
      wneg   <= wneg_n && an_s != 35'sd0;
    end
  end

  assign out_ch.valid        = res_valid;
  assign out_ch.left_view    = res_view;
  assign out_ch.blend_weight = res_w;
endmodule

FILE: src/avii_checker.sv
// port-level checker for the interpolator, bound to the top level
// depends on angular_view_index_interpolator ports
`timescale 1ns / 1ps
module avii_checker #(parameter int FRAC_BITS = 16) (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [5:0] left_view,
  input logic [FRAC_BITS:0] blend_weight
);
  // weight never exceeds one
  a_wmax: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> blend_weight <= ((FRAC_BITS+1)'(1) << FRAC_BITS)) else $error("weight");
  // a stalled result stays valid and keeps its left view
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_view)) else $error("hold");
  // left view never hits the top index
  a_lv: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> left_view != 6'd63) else $error("view");
  // in_valid, in_ready and out_valid are always known
  a_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown({in_valid, in_ready, out_valid})) else $error("known");
endmodule

bind angular_view_index_interpolator avii_checker #(.FRAC_BITS(FRAC_BITS)) u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .left_view(out_ch.left_view), .blend_weight(out_ch.blend_weight));
